>>> design/mude_pkg.sv
// Shared types, codes and widths of the mission upload and download engine.
package mude_pkg;

	// Field widths of one message and one reply.
	localparam int CMD_W      = 3;
	localparam int SEQ_W      = 16;
	localparam int MTYPE_W    = 8;
	localparam int HEADER_W   = 40;
	localparam int PARAMS_W   = 64;
	localparam int POSITION_W = 64;
	localparam int ALT_W      = 32;
	localparam int KIND_W     = 3;
	localparam int ACK_W      = 2;

	// Default number of table entries.
	localparam int DEFAULT_TABLE_DEPTH = 128;

	// Mission type of a plain mission.
	localparam logic [MTYPE_W-1:0] MTYPE_MISSION = '0;

	// Message commands.
	typedef enum logic [CMD_W-1:0] {
		CMD_COUNT    = 3'd0,
		CMD_ITEM     = 3'd1,
		CMD_LIST     = 3'd2,
		CMD_ITEM_REQ = 3'd3,
		CMD_LEGACY   = 3'd4,
		CMD_CLEAR    = 3'd5,
		CMD_ACK      = 3'd6,
		CMD_OTHER    = 3'd7
	} cmd_t;

	// Reply kinds.
	typedef enum logic [KIND_W-1:0] {
		KIND_NONE  = 3'd0,
		KIND_REQ   = 3'd1,
		KIND_ACK   = 3'd2,
		KIND_COUNT = 3'd3,
		KIND_ITEM  = 3'd4
	} kind_t;

	// Acknowledge codes.
	typedef enum logic [ACK_W-1:0] {
		ACK_OK          = 2'd0,
		ACK_ERROR       = 2'd1,
		ACK_UNSUPPORTED = 2'd2,
		ACK_NO_SPACE    = 2'd3
	} ack_t;

	// One stored mission item, as it sits in a table word.
	typedef struct packed {
		logic [HEADER_W-1:0]   header;
		logic [PARAMS_W-1:0]   params_low;
		logic [PARAMS_W-1:0]   params_high;
		logic [POSITION_W-1:0] position;
		logic [ALT_W-1:0]      altitude;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// One captured request.
	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [SEQ_W-1:0]   sequence_req;
		logic [SEQ_W-1:0]   item_total;
		logic [MTYPE_W-1:0] plan_type;
		entry_t             item;
	} msg_t;

endpackage

>>> design/mude_msg_if.sv
// Request channel that carries one decoded mission message.
interface mude_msg_if;
	import mude_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CMD_W-1:0]      command;
	logic [SEQ_W-1:0]      sequence_req;
	logic [SEQ_W-1:0]      item_total;
	logic [MTYPE_W-1:0]    plan_type;
	logic [HEADER_W-1:0]   item_header;
	logic [PARAMS_W-1:0]   item_params_low;
	logic [PARAMS_W-1:0]   item_params_high;
	logic [POSITION_W-1:0] item_position;
	logic [ALT_W-1:0]      item_altitude;

	modport source (
		output valid, command, sequence_req, item_total, plan_type, item_header,
			item_params_low, item_params_high, item_position, item_altitude,
		input  ready
	);

	modport sink (
		input  valid, command, sequence_req, item_total, plan_type, item_header,
			item_params_low, item_params_high, item_position, item_altitude,
		output ready
	);
endinterface

>>> design/mude_rsp_if.sv
// Reply channel that carries one reply of the mission engine.
interface mude_rsp_if;
	import mude_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [KIND_W-1:0]     reply_kind;
	logic [SEQ_W-1:0]      reply_number;
	logic [ACK_W-1:0]      ack_code;
	logic [HEADER_W-1:0]   out_header;
	logic [PARAMS_W-1:0]   out_params_low;
	logic [PARAMS_W-1:0]   out_params_high;
	logic [POSITION_W-1:0] out_position;
	logic [ALT_W-1:0]      out_altitude;
	logic                  handled;

	modport source (
		output valid, reply_kind, reply_number, ack_code, out_header, out_params_low,
			out_params_high, out_position, out_altitude, handled,
		input  ready
	);

	modport sink (
		input  valid, reply_kind, reply_number, ack_code, out_header, out_params_low,
			out_params_high, out_position, out_altitude, handled,
		output ready
	);
endinterface

>>> design/mission_upload_download_engine.sv
// Top level of the mission upload and download engine.
//
// Takes one decoded mission message per request and returns exactly one reply for each,
// kind none included. A message is captured into the request register and executed from it
// in the EXEC state, which waits while the output register holds an unaccepted reply; item
// and legacy item requests then pass through the READ state for the registered table read.
// The table is a single RAM of TABLE_DEPTH words that holds all item fields side by side;
// it is never cleared, so an entry reads back only after an upload has written it. A new
// message is taken while the previous reply still waits in the output register, but it
// executes only once that register is free. The upload session and stored count sit in
// flip-flops cleared by reset; there is no clearing pass.
module mission_upload_download_engine #(
	parameter int TABLE_DEPTH = mude_pkg::DEFAULT_TABLE_DEPTH
) (
	input logic    clk,
	input logic    arst_n,
	mude_msg_if.sink   msg,
	mude_rsp_if.source rsp
);
	import mude_pkg::*;

	localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam logic [SEQ_W:0] DEPTH_EXT = (SEQ_W + 1)'(TABLE_DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ
	} state_t;

	state_t state_q;
	msg_t   req_q;

	// Session state.
	logic [CNT_W-1:0] stored_count_q;
	logic             upload_active_q;
	logic [CNT_W-1:0] upload_expected_q;
	logic [CNT_W-1:0] next_wanted_q;

	// Output register.
	logic                 out_valid_q;
	logic [KIND_W-1:0]    out_kind_q;
	logic [SEQ_W-1:0]     out_number_q;
	logic [ACK_W-1:0]     out_code_q;
	entry_t               out_entry_q;
	logic                 out_handled_q;

	// Decision of the executing message.
	kind_t            dec_kind;
	logic [SEQ_W-1:0] dec_number;
	ack_t             dec_code;
	logic             dec_read;
	logic             dec_write;
	logic [CNT_W-1:0] nxt_count;
	logic             nxt_active;
	logic [CNT_W-1:0] nxt_expected;
	logic [CNT_W-1:0] nxt_wanted;

	logic   exec_go;
	logic   out_load;
	logic   mem_we;
	logic   mem_re;
	entry_t mem_rdata;
	logic [SEQ_W:0] seq_ext;
	logic [SEQ_W:0] total_ext;

	assign msg.ready = (state_q == ST_IDLE);
	assign exec_go   = (state_q == ST_EXEC) && (!out_valid_q || rsp.ready);
	assign seq_ext   = {1'b0, req_q.sequence_req};
	assign total_ext = {1'b0, req_q.item_total};

	// A new reply enters the output register at this edge.
	assign out_load  = (exec_go && !dec_read) || (state_q == ST_READ);

	// Capture the accepted request.
	always_ff @(posedge clk) begin
		if (msg.valid && msg.ready) begin
			req_q.command           <= msg.command;
			req_q.sequence_req      <= msg.sequence_req;
			req_q.item_total        <= msg.item_total;
			req_q.plan_type         <= msg.plan_type;
			req_q.item.header       <= msg.item_header;
			req_q.item.params_low   <= msg.item_params_low;
			req_q.item.params_high  <= msg.item_params_high;
			req_q.item.position     <= msg.item_position;
			req_q.item.altitude     <= msg.item_altitude;
		end
	end

	// Decide the reply and the new session state of the captured message.
	always_comb begin
		dec_kind     = KIND_NONE;
		dec_number   = '0;
		dec_code     = ACK_OK;
		dec_read     = 1'b0;
		dec_write    = 1'b0;
		nxt_count    = stored_count_q;
		nxt_active   = upload_active_q;
		nxt_expected = upload_expected_q;
		nxt_wanted   = next_wanted_q;
		case (cmd_t'(req_q.command))
			CMD_COUNT: begin
				if (req_q.plan_type != MTYPE_MISSION) begin
					dec_kind = KIND_ACK;
					dec_code = ACK_UNSUPPORTED;
				end else if (total_ext > DEPTH_EXT) begin
					dec_kind = KIND_ACK;
					dec_code = ACK_NO_SPACE;
				end else begin
					nxt_expected = CNT_W'(req_q.item_total);
					nxt_wanted   = '0;
					nxt_count    = '0;
					if (req_q.item_total == '0) begin
						nxt_active = 1'b0;
						dec_kind   = KIND_ACK;
					end else begin
						nxt_active = 1'b1;
						dec_kind   = KIND_REQ;
					end
				end
			end
			CMD_ITEM: begin
				if (upload_active_q) begin
					if (req_q.sequence_req != SEQ_W'(next_wanted_q) ||
						seq_ext >= DEPTH_EXT) begin
						dec_kind   = KIND_REQ;
						dec_number = SEQ_W'(next_wanted_q);
					end else begin
						dec_write  = 1'b1;
						nxt_wanted = CNT_W'(seq_ext + (SEQ_W + 1)'(1));
						if (nxt_wanted >= upload_expected_q) begin
							nxt_count  = upload_expected_q;
							nxt_active = 1'b0;
							dec_kind   = KIND_ACK;
						end else begin
							dec_kind   = KIND_REQ;
							dec_number = SEQ_W'(nxt_wanted);
						end
					end
				end
			end
			CMD_LIST: begin
				dec_kind   = KIND_COUNT;
				dec_number = SEQ_W'(stored_count_q);
			end
			CMD_ITEM_REQ, CMD_LEGACY: begin
				if (seq_ext >= (SEQ_W + 1)'(stored_count_q) || seq_ext >= DEPTH_EXT) begin
					dec_kind = KIND_ACK;
					dec_code = ACK_ERROR;
				end else begin
					dec_read = 1'b1;
				end
			end
			CMD_CLEAR: begin
				nxt_count  = '0;
				nxt_active = 1'b0;
				dec_kind   = KIND_ACK;
			end
			default: begin
			end
		endcase
	end

	assign mem_we = exec_go && dec_write;
	assign mem_re = exec_go && dec_read;

	// Item table.
	mude_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (req_q.sequence_req[ADDR_W-1:0]),
		.wdata (req_q.item),
		.re    (mem_re),
		.raddr (req_q.sequence_req[ADDR_W-1:0]),
		.rdata (mem_rdata)
	);

	// Sequencer, session state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			stored_count_q    <= '0;
			upload_active_q   <= 1'b0;
			upload_expected_q <= '0;
			next_wanted_q     <= '0;
			out_valid_q       <= 1'b0;
			out_kind_q        <= '0;
			out_number_q      <= '0;
			out_code_q        <= '0;
			out_entry_q       <= '0;
			out_handled_q     <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (msg.valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_go) begin
						stored_count_q    <= nxt_count;
						upload_active_q   <= nxt_active;
						upload_expected_q <= nxt_expected;
						next_wanted_q     <= nxt_wanted;
						if (dec_read) begin
							state_q <= ST_READ;
						end else begin
							state_q       <= ST_IDLE;
							out_valid_q   <= 1'b1;
							out_kind_q    <= dec_kind;
							out_number_q  <= dec_number;
							out_code_q    <= dec_code;
							out_entry_q   <= '0;
							out_handled_q <= (cmd_t'(req_q.command) != CMD_OTHER);
						end
					end
				end
				ST_READ: begin
					state_q       <= ST_IDLE;
					out_valid_q   <= 1'b1;
					out_kind_q    <= KIND_ITEM;
					out_number_q  <= req_q.sequence_req;
					out_code_q    <= ACK_OK;
					out_entry_q   <= mem_rdata;
					out_handled_q <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.reply_kind      = out_kind_q;
	assign rsp.reply_number    = out_number_q;
	assign rsp.ack_code        = out_code_q;
	assign rsp.out_header      = out_entry_q.header;
	assign rsp.out_params_low  = out_entry_q.params_low;
	assign rsp.out_params_high = out_entry_q.params_high;
	assign rsp.out_position    = out_entry_q.position;
	assign rsp.out_altitude    = out_entry_q.altitude;
	assign rsp.handled         = out_handled_q;

	// The read state always follows an executed item request.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> $past(state_q) == ST_EXEC && $past(mem_re))
		else $error("read state entered without a table read");

	// The output register is free whenever the table read data arrives.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> !out_valid_q)
		else $error("table read data would overwrite a pending reply");

	// The table is written only by an in-sequence item of an active upload.
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> upload_active_q && cmd_t'(req_q.command) == CMD_ITEM
			&& SEQ_W'(next_wanted_q) == req_q.sequence_req)
		else $error("table written outside an upload");

	// An active upload still waits for an item below the announced total.
	assert property (@(posedge clk) disable iff (!arst_n)
		upload_active_q |-> next_wanted_q < upload_expected_q)
		else $error("upload active with no item left to receive");

	// The stored count never exceeds the table depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		(SEQ_W + 1)'(stored_count_q) <= DEPTH_EXT)
		else $error("stored count beyond table depth");
endmodule

>>> design/mude_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module mude_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
